// ----- rtl/assert_macros.svh -----
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) !rst_n |=> prop) \
    else $error("assertion failed after reset");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_RST(label, clk, rst_n, prop)
`endif
`endif

// ----- rtl/obwf_pkg.sv -----
// types, constants and helpers for the oriented box wall force cell
`default_nettype none
package obwf_pkg;
  localparam int unsigned GridDim = 256;
  localparam int unsigned IdxW = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegRotX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRotY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRotZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCentre = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHalf = 3'd4;
  localparam logic [CfgIdxW-1:0] RegVel = 3'd5;
  localparam logic [CfgIdxW-1:0] RegGain = 3'd6;
  localparam logic [CfgIdxW-1:0] RegCell = 3'd7;

  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindInside = 2'd1;
  localparam logic [1:0] KindTouch = 2'd2;

  // position in 1/512 units: (2*idx+1)*cell up to ~2^25, +-2 cells
  localparam int unsigned PosW = 28;
  // relative position: pos - 2*centre
  localparam int unsigned RelW = 29;
  // rotated coordinate: 3 products of 16x29
  localparam int unsigned RotW = 47;
  localparam int unsigned RedW = 34;

  typedef struct packed {
    logic [7:0] cell_i;
    logic [7:0] cell_j;
    logic [7:0] cell_k;
    logic signed [15:0] fluid_vx;
    logic signed [15:0] fluid_vy;
    logic signed [15:0] fluid_vz;
    logic signed [31:0] force_in_x;
    logic signed [31:0] force_in_y;
    logic signed [31:0] force_in_z;
    logic done_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] force_out_x;
    logic signed [31:0] force_out_y;
    logic signed [31:0] force_out_z;
    logic done_out;
    logic [1:0] contact_kind;
  } out_beat_t;

  typedef struct packed {
    logic [47:0] rot_x;
    logic [47:0] rot_y;
    logic [47:0] rot_z;
    logic [47:0] centre;
    logic [47:0] half;
    logic [47:0] vel;
    logic [15:0] gain;
    logic [15:0] cell_len;
  } cfg_t;

  // per item data carried alongside the geometry
  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic signed [RedW-1:0] rx;
    logic signed [RedW-1:0] ry;
    logic signed [RedW-1:0] rz;
    logic done;
    logic active;
  } side_t;

  function automatic logic signed [15:0] lane_s(input logic [47:0] r, input int unsigned a);
    lane_s = r[16*a +: 16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [RedW+2:0] v);
    if (v > $signed({{(RedW-29){1'b0}}, 32'h7fffffff})) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -$signed({{(RedW-29){1'b0}}, 32'h80000000})) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction
endpackage
`default_nettype wire

// ----- rtl/oriented_box_wall_force_cell.sv -----
// top level: oriented box wall force for one grid cell per beat
// Takes one cell per clock while ready is high and returns one result per cell from the
// output register. Stages: cell positions and reductions, matrix products,
// rotated-sum compare, hit count, force update and saturation.
// Ready falls only when the output register holds an untaken beat and the
// last stage holds a beat; a stall freezes every stage together.
`default_nettype none
module oriented_box_wall_force_cell (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire obwf_pkg::in_beat_t in_data_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output obwf_pkg::out_beat_t out_data_o,
  input  wire logic cfg_valid_i,
  output logic cfg_ready_o,
  input  wire logic [obwf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [47:0] cfg_data_i
);
  import obwf_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned Depth = 4;
  cfg_t cfg;
  logic en;
  logic [Depth-1:0] vld_q;
  side_t side_q [Depth];
  side_t side_d;
  logic signed [RelW-1:0] rel_q [7][3];
  logic signed [RelW-1:0] rel_d [7][3];
  logic [6:0] pt_hit;
  logic [1:0] hits [3];
  logic [1:0] hits_q [3];
  logic cin_q;
  logic any_q;
  out_beat_t res_d;
  out_beat_t out_q;
  logic out_vld_q;
  logic signed [PosW-1:0] pos [3];
  logic valid_idx;

  obwf_regs u_regs (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i, .cfg_o(cfg)
  );

  assign en = !out_vld_q || out_ready_i || !vld_q[Depth-1];
  assign in_ready_o = en;

  // stage 0: positions and reductions
  always_comb begin
    valid_idx = (32'(in_data_i.cell_i) < GridDim) && (32'(in_data_i.cell_j) < GridDim)
             && (32'(in_data_i.cell_k) < GridDim);
    pos[0] = PosW'({in_data_i.cell_i, 1'b1}) * PosW'(cfg.cell_len);
    pos[1] = PosW'({in_data_i.cell_j, 1'b1}) * PosW'(cfg.cell_len);
    pos[2] = PosW'({in_data_i.cell_k, 1'b1}) * PosW'(cfg.cell_len);
    for (int n = 0; n < 7; n++) begin
      for (int a = 0; a < 3; a++) begin
        rel_d[n][a] = RelW'(pos[a]) - RelW'($signed({lane_s(cfg.centre, a), 1'b0}));
        if (n == 2*a + 1) begin
          rel_d[n][a] = rel_d[n][a] - RelW'({cfg.cell_len, 1'b0});
        end else if (n == 2*a + 2) begin
          rel_d[n][a] = rel_d[n][a] + RelW'({cfg.cell_len, 1'b0});
        end
      end
    end
    side_d.fx = in_data_i.force_in_x;
    side_d.fy = in_data_i.force_in_y;
    side_d.fz = in_data_i.force_in_z;
    side_d.rx = $signed({1'b0, cfg.gain}) * (RedW'(in_data_i.fluid_vx) - RedW'(lane_s(cfg.vel, 0)));
    side_d.ry = $signed({1'b0, cfg.gain}) * (RedW'(in_data_i.fluid_vy) - RedW'(lane_s(cfg.vel, 1)));
    side_d.rz = $signed({1'b0, cfg.gain}) * (RedW'(in_data_i.fluid_vz) - RedW'(lane_s(cfg.vel, 2)));
    side_d.done = in_data_i.done_in;
    side_d.active = !in_data_i.done_in && valid_idx;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rel_q <= rel_d;
      side_q[0] <= side_d;
      for (int s = 1; s < Depth; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // stages 1 and 2: seven point tests
  for (genvar n = 0; n < 7; n++) begin : g_pt
    obwf_point u_pt (
      .clk_i, .en_i(en), .cfg_i(cfg),
      .rel_x_i(rel_q[n][0]), .rel_y_i(rel_q[n][1]), .rel_z_i(rel_q[n][2]),
      .inside_o(pt_hit[n])
    );
  end

  // stage 3: hit counts
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (!side_q[2].active) begin
        hits[a] = 2'd0;
      end else if (pt_hit[0]) begin
        hits[a] = 2'd1;
      end else begin
        hits[a] = 2'({1'b0, pt_hit[2*a+1]} + {1'b0, pt_hit[2*a+2]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hits_q <= hits;
      cin_q <= side_q[2].active && pt_hit[0];
      any_q <= side_q[2].active && (|pt_hit);
    end
  end

  // stage 4: force update
  always_comb begin
    res_d.force_out_x = sat32((RedW+3)'(side_q[3].fx)
      - $signed({1'b0, hits_q[0]}) * (RedW+3)'(side_q[3].rx));
    res_d.force_out_y = sat32((RedW+3)'(side_q[3].fy)
      - $signed({1'b0, hits_q[1]}) * (RedW+3)'(side_q[3].ry));
    res_d.force_out_z = sat32((RedW+3)'(side_q[3].fz)
      - $signed({1'b0, hits_q[2]}) * (RedW+3)'(side_q[3].rz));
    res_d.contact_kind = cin_q ? KindInside : any_q ? KindTouch : KindNone;
    res_d.done_out = side_q[3].done || cin_q || any_q;
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[Depth-1]) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= (en && vld_q[Depth-1]) || (out_vld_q && !out_ready_i);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o = out_q;

  `ASSERT_CLK(a_stall_holds, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)
  `ASSERT_CLK(a_ready_free, clk_i, rst_ni, !out_valid_o |-> in_ready_o)
  `ASSERT_CLK(a_kind_done, clk_i, rst_ni, out_valid_o && out_data_o.contact_kind != KindNone |-> out_data_o.done_out)
  `ASSERT_RST(a_reset_empty, clk_i, rst_ni, !out_valid_o)
endmodule
`default_nettype wire

// ----- rtl/obwf_regs.sv -----
// configuration register file
`default_nettype none
module obwf_regs (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_valid_i,
  output logic cfg_ready_o,
  input  wire logic [obwf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [47:0] cfg_data_i,
  output obwf_pkg::cfg_t cfg_o
);
  import obwf_pkg::*;
  cfg_t cfg_q;
  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_x <= 48'd16384;
      cfg_q.rot_y <= 48'd1073741824;
      cfg_q.rot_z <= 48'd70368744177664;
      cfg_q.centre <= '0;
      cfg_q.half <= '0;
      cfg_q.vel <= '0;
      cfg_q.gain <= '0;
      cfg_q.cell_len <= 16'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegRotX: cfg_q.rot_x <= cfg_data_i;
        RegRotY: cfg_q.rot_y <= cfg_data_i;
        RegRotZ: cfg_q.rot_z <= cfg_data_i;
        RegCentre: cfg_q.centre <= cfg_data_i;
        RegHalf: cfg_q.half <= cfg_data_i;
        RegVel: cfg_q.vel <= cfg_data_i;
        RegGain: cfg_q.gain <= cfg_data_i[15:0];
        RegCell: cfg_q.cell_len <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/obwf_point.sv -----
// rotate and test one point against the box over two stages
`default_nettype none
module obwf_point (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire obwf_pkg::cfg_t cfg_i,
  input  wire logic signed [obwf_pkg::RelW-1:0] rel_x_i,
  input  wire logic signed [obwf_pkg::RelW-1:0] rel_y_i,
  input  wire logic signed [obwf_pkg::RelW-1:0] rel_z_i,
  output logic inside_o
);
  import obwf_pkg::*;
  logic signed [RelW+15:0] prod_q [9];
  logic signed [RelW+15:0] prod_d [9];
  logic hit;
  logic signed [RotW-1:0] acc [3];
  logic [RotW-1:0] mag [3];
  logic [RotW-1:0] lim [3];
  logic inside_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod_d[3*a]   = lane_s(a == 0 ? cfg_i.rot_x : a == 1 ? cfg_i.rot_y : cfg_i.rot_z, 0) * rel_x_i;
      prod_d[3*a+1] = lane_s(a == 0 ? cfg_i.rot_x : a == 1 ? cfg_i.rot_y : cfg_i.rot_z, 1) * rel_y_i;
      prod_d[3*a+2] = lane_s(a == 0 ? cfg_i.rot_x : a == 1 ? cfg_i.rot_y : cfg_i.rot_z, 2) * rel_z_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    hit = 1'b1;
    for (int a = 0; a < 3; a++) begin
      acc[a] = RotW'(prod_q[3*a]) + RotW'(prod_q[3*a+1]) + RotW'(prod_q[3*a+2]);
      mag[a] = acc[a] < 0 ? RotW'(-acc[a]) : RotW'(acc[a]);
      lim[a] = {{(RotW-31){1'b0}}, cfg_i.half[16*a +: 16], 15'd0};
      if (mag[a] > lim[a]) begin
        hit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inside_q <= hit;
    end
  end
  assign inside_o = inside_q;
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for the oriented box wall force cell
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import obwf_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int HoldCycles = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  oriented_box_wall_force_cell i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  logic [47:0] rot_x, rot_y, rot_z, centre, half, vel;
  logic [15:0] gain, cell_len;

  in_beat_t cell_queue[$];
  out_beat_t force_queue[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [15:0] lane(input logic [47:0] r, input int a);
    return r[16*a +: 16];
  endfunction

  function automatic bit point_in_box(input longint p[3]);
    longint rel[3];
    longint acc;
    logic [47:0] rows[3];
    rows[0] = rot_x; rows[1] = rot_y; rows[2] = rot_z;
    for (int a = 0; a < 3; a++) rel[a] = p[a] - 2 * longint'(lane(centre, a));
    for (int a = 0; a < 3; a++) begin
      acc = 0;
      for (int c = 0; c < 3; c++) acc += longint'(lane(rows[a], c)) * rel[c];
      if (acc < 0) acc = -acc;
      if (acc > longint'(half[16*a +: 16]) * 32768) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic out_beat_t wall_force(input in_beat_t b);
    out_beat_t r;
    longint ctr[3], q[3], red[3], f;
    logic signed [15:0] v[3];
    logic signed [31:0] fin[3];
    logic [7:0] idx[3];
    int hits[3];
    logic [1:0] kind;
    idx = '{b.cell_i, b.cell_j, b.cell_k};
    v = '{b.fluid_vx, b.fluid_vy, b.fluid_vz};
    fin = '{b.force_in_x, b.force_in_y, b.force_in_z};
    hits = '{0, 0, 0};
    kind = KindNone;
    for (int a = 0; a < 3; a++) begin
      red[a] = longint'(gain) * (longint'(v[a]) - longint'(lane(vel, a)));
      ctr[a] = (2 * longint'(idx[a]) + 1) * longint'(cell_len);
    end
    if (!b.done_in) begin
      if (point_in_box(ctr)) begin
        kind = KindInside;
        hits = '{1, 1, 1};
      end else begin
        for (int a = 0; a < 3; a++)
          for (int s = -1; s <= 1; s += 2) begin
            q = ctr;
            q[a] += s * 2 * longint'(cell_len);
            if (point_in_box(q)) hits[a]++;
          end
        if (hits[0] + hits[1] + hits[2] != 0) kind = KindTouch;
      end
    end
    for (int a = 0; a < 3; a++) begin
      f = longint'(fin[a]) - hits[a] * red[a];
      if (f > 64'sd2147483647) f = 64'sd2147483647;
      if (f < -64'sd2147483648) f = -64'sd2147483648;
      if (a == 0) r.force_out_x = f[31:0];
      else if (a == 1) r.force_out_y = f[31:0];
      else r.force_out_z = f[31:0];
    end
    r.done_out = b.done_in || kind != KindNone;
    r.contact_kind = kind;
    return r;
  endfunction

  // sender
  int send_gap = 0;
  always @(posedge clk) begin
    if (in_valid && in_ready) force_queue = {force_queue, wall_force(in_data)};
    if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (cell_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= cell_queue.pop_front();
        if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  int recv_gap = 0;
  out_beat_t want;
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (force_queue.size() == 0) begin
        $error("unexpected beat %h", out_data);
        errors++;
      end else begin
        want = force_queue.pop_front();
        if (out_data.force_out_x !== want.force_out_x) begin
          $error("force_out_x exp %h got %h", want.force_out_x, out_data.force_out_x); errors++;
        end
        if (out_data.force_out_y !== want.force_out_y) begin
          $error("force_out_y exp %h got %h", want.force_out_y, out_data.force_out_y); errors++;
        end
        if (out_data.force_out_z !== want.force_out_z) begin
          $error("force_out_z exp %h got %h", want.force_out_z, out_data.force_out_z); errors++;
        end
        if (out_data.done_out !== want.done_out) begin
          $error("done_out exp %b got %b", want.done_out, out_data.done_out); errors++;
        end
        if (out_data.contact_kind !== want.contact_kind) begin
          $error("contact_kind exp %0d got %0d", want.contact_kind, out_data.contact_kind);
          errors++;
        end
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && hold_cnt < HoldCycles) begin
      hold_cnt <= hold_cnt + 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      recv_gap <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      RegRotX: rot_x = val;
      RegRotY: rot_y = val;
      RegRotZ: rot_z = val;
      RegCentre: centre = val;
      RegHalf: half = val;
      RegVel: vel = val;
      RegGain: gain = val[15:0];
      default: cell_len = val[15:0];
    endcase
  endtask

  task automatic drain();
    while (cell_queue.size() > 0 || in_valid || force_queue.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic in_beat_t rand_cell(input int near);
    in_beat_t b;
    b.cell_i = near ? 8'($urandom_range(0, 15)) : 8'($urandom);
    b.cell_j = near ? 8'($urandom_range(0, 15)) : 8'($urandom);
    b.cell_k = near ? 8'($urandom_range(0, 15)) : 8'($urandom);
    b.fluid_vx = 16'($urandom); b.fluid_vy = 16'($urandom); b.fluid_vz = 16'($urandom);
    b.force_in_x = $urandom; b.force_in_y = $urandom; b.force_in_z = $urandom;
    if ($urandom_range(0, 7) == 0) begin
      b.force_in_x = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
    end
    b.done_in = $urandom_range(0, 7) == 0;
    return b;
  endfunction

  // random geometry around the first few cells; rotation is one of three fixed shapes or random bits
  task automatic random_setup(input int mode);
    logic [47:0] r[3];
    int sh;
    sh = $urandom_range(0, 3);
    case (mode)
      0: r = '{48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000};
      1: r = '{48'h0000_2d41_2d41, 48'h0000_2d41_d2bf, 48'h4000_0000_0000};
      2: r = '{48'h8000_8000_8000, 48'h7fff_7fff_7fff, 48'h8000_7fff_8000};
      default: r = '{48'($urandom) | (48'($urandom) << 32), 48'($urandom) << 16,
                     {16'($urandom), 32'($urandom)}};
    endcase
    write_reg(RegRotX, r[0]);
    write_reg(RegRotY, r[1]);
    write_reg(RegRotZ, r[2]);
    write_reg(RegCell, 48'(sh == 0 ? 16'h0000 : sh == 1 ? 16'hffff
                                                        : 16'($urandom_range(64, 512))));
    write_reg(RegCentre, {16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)),
                          16'($urandom_range(0, 4096))});
    write_reg(RegHalf, {16'($urandom_range(0, 2048)), 16'($urandom_range(0, 2048)),
                        16'($urandom_range(0, 2048))});
    write_reg(RegVel, {16'($urandom), 16'($urandom), 16'($urandom)});
    write_reg(RegGain, 48'($urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom)));
  endtask

  in_beat_t d;
  initial begin
    rot_x = 48'h0000_0000_4000; rot_y = 48'h0000_4000_0000; rot_z = 48'h4000_0000_0000;
    centre = '0; half = '0; vel = '0; gain = '0; cell_len = 16'd256;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: box covering a few cells, full gain, extremes
    write_reg(RegCentre, {16'h0300, 16'h0300, 16'h0300});
    write_reg(RegHalf, {16'h0100, 16'h0100, 16'h0100});
    write_reg(RegVel, {16'h8000, 16'h7fff, 16'h0000});
    write_reg(RegGain, 48'h00_0000_ffff);
    for (int n = 0; n < 20; n++) begin
      d = '0;
      d.cell_i = n < 6 ? 8'(n) : (n < 10 ? 8'd255 : 8'(2 + n % 3));
      d.cell_j = n % 2 ? 8'd3 : 8'd2;
      d.cell_k = n % 4 == 0 ? 8'd255 : 8'd2;
      d.fluid_vx = n % 3 == 0 ? 16'sh7fff : 16'sh8000;
      d.fluid_vy = n % 2 ? 16'sh8000 : 16'sh7fff;
      d.fluid_vz = 16'(n * 1234);
      d.force_in_x = n % 2 ? 32'sh7fffffff : 32'sh80000000;
      d.force_in_y = n % 3 ? 32'sh80000000 : 32'sh7fffffff;
      d.force_in_z = 32'hffffffff;
      d.done_in = n == 7 || n == 13;
      cell_queue = {cell_queue, d};
    end
    drain();
    write_reg(RegCell, 48'h0);
    d = '0;
    cell_queue = {cell_queue, d};
    drain();
    // random phases, with one long receiver hold-off
    for (int ph = 0; ph < 18; ph++) begin
      random_setup(ph % 4);
      if (ph == 17) quiet = 1'b1;
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < 100; n++) begin
        cell_queue = {cell_queue, rand_cell($urandom_range(0, 4) != 0)};
      end
      drain();
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
